// File: rtl/core/cwp_pkg.sv
// Shared constants, status codes and controller/datapath interface types of the way partitioner.
package cwp_pkg;

  localparam int MASK_BITS_DEF = 32;
  localparam int CORE_BITS     = 32;
  localparam int CNT_W         = 6;
  localparam int ID_W          = 5;
  localparam int STAT_W        = 3;
  localparam int SLICE_W       = 32;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_WAYS_ZERO = 3'd1;
  localparam logic [STAT_W-1:0] ST_SPLIT     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_CORES  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FEW_WAYS  = 3'd4;

  typedef struct packed {
    logic              load;
    logic              count_step;
    logic              div_init;
    logic              div_step;
    logic              base_init;
    logic              search_step;
    logic              emit;
    logic              emit_error;
    logic [STAT_W-1:0] err_code;
  } cwp_cmd_t;

  typedef struct packed {
    logic ways_zero;
    logic ways_split;
    logic scan_last;
    logic cores_none;
    logic div_last;
    logic width_zero;
    logic search_done;
    logic emit_last;
  } cwp_stat_t;

endpackage

// File: rtl/core/cwp_ctrl.sv
// Sequencing state machine of the way partitioner.
module cwp_ctrl import cwp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  cwp_stat_t stat,
  output cwp_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_COUNT, S_NCHK, S_DIV, S_WCHK, S_SEARCH, S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.err_code = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.ways_zero) begin
          cmd.emit_error = 1'b1;
          cmd.err_code   = ST_WAYS_ZERO;
          state_next     = S_IDLE;
        end else if (stat.ways_split) begin
          cmd.emit_error = 1'b1;
          cmd.err_code   = ST_SPLIT;
          state_next     = S_IDLE;
        end else begin
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd.count_step = 1'b1;
        if (stat.scan_last) state_next = S_NCHK;
      end
      S_NCHK: begin
        if (stat.cores_none) begin
          cmd.emit_error = 1'b1;
          cmd.err_code   = ST_NO_CORES;
          state_next     = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_WCHK;
      end
      S_WCHK: begin
        if (stat.width_zero) begin
          cmd.emit_error = 1'b1;
          cmd.err_code   = ST_FEW_WAYS;
          state_next     = S_IDLE;
        end else begin
          cmd.base_init = 1'b1;
          state_next    = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (stat.search_done) begin
          state_next = S_EMIT;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// File: rtl/core/cwp_datapath.sv
// Datapath of the way partitioner: bit counters, divider, base search and class output.
module cwp_datapath import cwp_pkg::*; #(
  parameter int MASK_BITS = MASK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cwp_cmd_t             cmd,
  output cwp_stat_t            stat,
  input  logic [CORE_BITS-1:0] core_select,
  input  logic [CORE_BITS-1:0] way_mask_in,
  output logic                 strobe,
  output logic [ID_W-1:0]      class_id,
  output logic [ID_W-1:0]      core_index,
  output logic [SLICE_W-1:0]   slice_mask,
  output logic [CNT_W-1:0]     class_count,
  output logic [STAT_W-1:0]    status,
  output logic                 last
);

  localparam int SCAN_LEN = (MASK_BITS > CORE_BITS) ? MASK_BITS : CORE_BITS;
  localparam int SCAN_W   = $clog2(SCAN_LEN);
  localparam int WC_W     = $clog2(MASK_BITS + 1);
  localparam int DIV_W    = $clog2(WC_W);

  logic [CORE_BITS-1:0] rem_cores;
  logic [MASK_BITS-1:0] ways;
  logic [SCAN_LEN-1:0]  scan_c;
  logic [SCAN_LEN-1:0]  scan_w;
  logic [SCAN_W-1:0]    scan_cnt;
  logic [CNT_W-1:0]     n_cores;
  logic [WC_W-1:0]      n_ways;
  logic [WC_W-1:0]      div_q;
  logic [CNT_W-1:0]     div_r;
  logic [DIV_W-1:0]     div_cnt;
  logic [MASK_BITS-1:0] base;
  logic [WC_W-1:0]      srch_cnt;
  logic [ID_W-1:0]      k;

  logic [SCAN_LEN-1:0]  ways_wide;
  logic [MASK_BITS-1:0] ways_in;
  logic [MASK_BITS-1:0] ways_lsb;
  logic [MASK_BITS-1:0] ways_sum;
  logic [CNT_W:0]       div_trial;
  logic [MASK_BITS:0]   one_wide;
  logic [MASK_BITS:0]   run_wide;
  logic [MASK_BITS-1:0] base_shl;
  logic [SCAN_LEN-1:0]  base_wide;
  logic [ID_W-1:0]      low_idx;
  logic [CNT_W-1:0]     k_plus;

  assign ways_wide = SCAN_LEN'(way_mask_in);
  assign ways_in   = ways_wide[MASK_BITS-1:0];

  // A mask is one run when adding its lowest set bit clears every set bit.
  assign ways_lsb = ways & (~ways + MASK_BITS'(1));
  assign ways_sum = ways + ways_lsb;

  assign div_trial = {div_r, n_ways[WC_W-1]} - {1'b0, n_cores};
  assign one_wide  = (MASK_BITS + 1)'(1) << div_q;
  assign run_wide  = one_wide - (MASK_BITS + 1)'(1);
  assign base_shl  = base << div_q;
  assign base_wide = SCAN_LEN'(base);
  assign k_plus    = CNT_W'(k) + CNT_W'(1);

  always_comb begin
    low_idx = '0;
    for (int i = CORE_BITS - 1; i >= 0; i--) begin
      if (rem_cores[i]) low_idx = ID_W'(i);
    end
  end

  assign stat.ways_zero   = (ways == '0);
  assign stat.ways_split  = ((ways_sum & ways) != '0);
  assign stat.scan_last   = (scan_cnt == SCAN_W'(SCAN_LEN - 1));
  assign stat.cores_none  = (n_cores == '0);
  assign stat.div_last    = (div_cnt == DIV_W'(WC_W - 1));
  assign stat.width_zero  = (div_q == '0);
  assign stat.search_done = (srch_cnt == WC_W'(MASK_BITS)) || ((base & ways) != '0)
                            || (base_shl == '0);
  assign stat.emit_last   = (k_plus == n_cores);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_cores <= core_select;
      ways      <= ways_in;
      scan_c    <= SCAN_LEN'(core_select);
      scan_w    <= SCAN_LEN'(ways_in);
      scan_cnt  <= '0;
      n_cores   <= '0;
      n_ways    <= '0;
    end
    if (cmd.count_step) begin
      scan_c   <= scan_c >> 1;
      scan_w   <= scan_w >> 1;
      scan_cnt <= scan_cnt + SCAN_W'(1);
      n_cores  <= n_cores + CNT_W'(scan_c[0]);
      n_ways   <= n_ways + WC_W'(scan_w[0]);
    end
    // Restoring divide: the dividend shifts out of n_ways while quotient bits shift in.
    if (cmd.div_init) begin
      div_r   <= '0;
      div_cnt <= '0;
      div_q   <= '0;
    end
    if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_W'(1);
      n_ways  <= n_ways << 1;
      if (!div_trial[CNT_W]) begin
        div_r <= div_trial[CNT_W-1:0];
        div_q <= {div_q[WC_W-2:0], 1'b1};
      end else begin
        div_r <= {div_r[CNT_W-2:0], n_ways[WC_W-1]};
        div_q <= {div_q[WC_W-2:0], 1'b0};
      end
    end
    if (cmd.base_init) begin
      base     <= run_wide[MASK_BITS-1:0];
      srch_cnt <= '0;
      k        <= '0;
    end
    if (cmd.search_step) begin
      base     <= base_shl;
      srch_cnt <= srch_cnt + WC_W'(1);
    end
    if (cmd.emit) begin
      base               <= base_shl;
      k                  <= k + ID_W'(1);
      rem_cores[low_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit || cmd.emit_error;
    end
    if (cmd.emit) begin
      class_id    <= k;
      core_index  <= low_idx;
      slice_mask  <= base_wide[SLICE_W-1:0];
      class_count <= n_cores;
      status      <= ST_OK;
      last        <= stat.emit_last;
    end else if (cmd.emit_error) begin
      class_id    <= '0;
      core_index  <= '0;
      slice_mask  <= '0;
      class_count <= '0;
      status      <= cmd.err_code;
      last        <= 1'b1;
    end
  end

endmodule

// File: rtl/core/cache_way_partitioner_top.sv
// Cache way partitioner: one request word in, one class word per selected core out.
// Steps: a zero or split way mask is rejected at the first check; otherwise the set bits of
// both masks are counted, an empty core selection is rejected, the way count is divided by
// the core count, a zero width is rejected, the base search shifts the run up to the way
// mask, then one class word is sent per cycle. Every rejection sends one error word.
// One request at a time; busy stays high until the last word. The receiver cannot stall.
// Synchronous active-high reset returns the controller to idle and clears the strobe.
module cache_way_partitioner_top import cwp_pkg::*; #(
  parameter int MASK_BITS = MASK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [CORE_BITS-1:0] core_select,
  input  logic [CORE_BITS-1:0] way_mask_in,
  output logic                 strobe,
  output logic [ID_W-1:0]      class_id,
  output logic [ID_W-1:0]      core_index,
  output logic [SLICE_W-1:0]   slice_mask,
  output logic [CNT_W-1:0]     class_count,
  output logic [STAT_W-1:0]    status,
  output logic                 last
);

  cwp_cmd_t  cmd;
  cwp_stat_t stat;

  cwp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  cwp_datapath #(
    .MASK_BITS (MASK_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .core_select (core_select),
    .way_mask_in (way_mask_in),
    .strobe      (strobe),
    .class_id    (class_id),
    .core_index  (core_index),
    .slice_mask  (slice_mask),
    .class_count (class_count),
    .status      (status),
    .last        (last)
  );

endmodule
